@@ src/pov_column_timing_serve_assert.svh @@
// ----------------------------------------------------------------------------
// pov column timing serve assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef POV_COLUMN_TIMING_SERVE_ASSERT_SVH
`define POV_COLUMN_TIMING_SERVE_ASSERT_SVH

// same-cycle implication
`define POVCTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define POVCTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/povcts_pkg.sv @@
// ----------------------------------------------------------------------------
// povcts_pkg
// item types and fixed constants of the pov column timing block
// ----------------------------------------------------------------------------
package povcts_pkg;

	localparam int TIME_W = 48;
	localparam int CFG_W  = 20;
	localparam int WORD_W = 32;

	localparam logic [CFG_W-1:0]  MIN_TURN_RESET = 20'd10000;
	localparam logic [TIME_W-1:0] PERIOD_RESET   = 48'd102400;
	localparam logic [WORD_W-1:0] BLACK_WORD     = 32'h0000_00e0;

	localparam logic [1:0] REQ_HALL    = 2'd0;
	localparam logic [1:0] REQ_POLL    = 2'd1;
	localparam logic [1:0] REQ_WRITE   = 2'd2;
	localparam logic [1:0] REQ_PUBLISH = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [TIME_W-1:0] timestamp_us;
		logic [7:0]        column_index;
		logic [5:0]        led_index;
		logic [WORD_W-1:0] pixel_word;
	} req_t;

	typedef struct packed {
		logic [7:0]        column_served;
		logic [WORD_W-1:0] outer_arm_word;
		logic [WORD_W-1:0] inner_arm_word;
		logic              last_of_column;
	} rsp_t;

endpackage

@@ src/povcts_ram.sv @@
// ----------------------------------------------------------------------------
// povcts_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module povcts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ src/povcts_div.sv @@
// ----------------------------------------------------------------------------
// povcts_div
// angular column unit: elapsed * COLUMNS / period, quotient kept mod COLUMNS,
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module povcts_div #(
	parameter int COLUMNS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [povcts_pkg::TIME_W-1:0] elapsed,
	input  logic [povcts_pkg::TIME_W-1:0] period,
	output logic                          done,
	output logic [$clog2(COLUMNS)-1:0]    column
);

	import povcts_pkg::*;

	localparam int CW   = $clog2(COLUMNS);
	localparam int NW   = TIME_W + $clog2(COLUMNS + 1);
	localparam int CNTW = $clog2(NW + 1);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_RUN  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [1:0]        phase_q;
	logic [CNTW-1:0]   cnt_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] dvs_q;
	logic [NW-1:0]     num_q;
	logic [TIME_W-1:0] rem_q;
	logic [CW-1:0]     qmod_q;

	logic [TIME_W:0]   trial;
	logic              ge;
	logic [TIME_W:0]   diff;
	logic [CW:0]       qm2;
	logic [CW:0]       qm_next;

	always_comb begin
		trial   = {rem_q, num_q[NW-1]};
		ge      = trial >= {1'b0, dvs_q};
		diff    = trial - {1'b0, dvs_q};
		qm2     = {qmod_q, ge};
		qm_next = (qm2 >= (CW+1)'(COLUMNS)) ? qm2 - (CW+1)'(COLUMNS) : qm2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
					end
				end
				PH_MUL: begin
					phase_q <= PH_RUN;
					cnt_q   <= CNTW'(NW);
				end
				PH_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						phase_q <= PH_DONE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			elapsed_q <= elapsed;
			dvs_q     <= (period == '0) ? TIME_W'(1) : period;
		end
		if (phase_q == PH_MUL) begin
			num_q  <= NW'(elapsed_q) * NW'(COLUMNS);
			rem_q  <= '0;
			qmod_q <= '0;
		end
		if (phase_q == PH_RUN) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			qmod_q <= qm_next[CW-1:0];
		end
	end

	assign done   = (phase_q == PH_DONE);
	assign column = qmod_q;

endmodule

@@ src/pov_column_timing_serve.sv @@
// ----------------------------------------------------------------------------
// pov_column_timing_serve
// rotation timing from hall edges, angular column from time polls, and
// serving of led word pairs from a double-buffered frame ram
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  povcts_pkg::req_t
//  rsp      out        rsp_valid/rsp_ready  povcts_pkg::rsp_t
//  cfg      in         cfg_we               cfg_wdata, min turn in us
//
// hall edge, frame write and publish are handled as they are accepted in idle.
// a poll runs the divider, then, if the column has changed, serves each led
// pair through the frame ram read ports, a read state then a load state per pair.
// after reset a clearing pass over all 2^(1+clog2(COLUMNS)+clog2(LEDS)) words
// (32768 by default) fills the frame ram with black, req_ready held low.
// a full output register lets rsp_ready stall serving without losing items.
// ----------------------------------------------------------------------------
`include "pov_column_timing_serve_assert.svh"

module pov_column_timing_serve #(
	parameter int COLUMNS = 256,
	parameter int LEDS    = 54
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  povcts_pkg::req_t             req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output povcts_pkg::rsp_t             rsp,
	input  logic                         cfg_we,
	input  logic [povcts_pkg::CFG_W-1:0] cfg_wdata
);

	import povcts_pkg::*;

	localparam int CW    = $clog2(COLUMNS);
	localparam int LW    = (LEDS > 1) ? $clog2(LEDS) : 1;
	localparam int AW    = 1 + CW + LW;
	localparam int DEPTH = 2 ** AW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_LD    = 3'd4;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [CFG_W-1:0]  min_turn_q;
	logic [TIME_W-1:0] start_time_q;
	logic [TIME_W-1:0] period_q;
	logic [CW-1:0]     prev_col_q;
	logic              front_q;
	logic [CW-1:0]     col_q;
	logic [CW-1:0]     opp_q;
	logic [LW-1:0]     k_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              acc;
	logic [TIME_W-1:0] dur;
	logic              wr_ok;
	logic              div_start;
	logic              div_done;
	logic [CW-1:0]     div_col;
	logic [CW:0]       opp_sum;
	logic [CW:0]       opp_wrap;
	logic              load;
	logic              last_k;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr_a;
	logic [AW-1:0]     ram_raddr_b;
	logic [WORD_W-1:0] ram_rdata_a;
	logic [WORD_W-1:0] ram_rdata_b;

	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign dur       = req.timestamp_us - start_time_q;
	assign wr_ok     = (32'(req.column_index) < 32'(COLUMNS)) &&
	                   (32'(req.led_index) < 32'(LEDS));
	assign div_start = acc && (req.req_type == REQ_POLL);

	assign opp_sum  = {1'b0, div_col} + (CW+1)'(COLUMNS / 2);
	assign opp_wrap = (opp_sum >= (CW+1)'(COLUMNS)) ? opp_sum - (CW+1)'(COLUMNS) : opp_sum;

	assign last_k = (k_q == LW'(LEDS - 1));
	assign load   = (state_q == ST_LD) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {!front_q, CW'(req.column_index), LW'(req.led_index)};
		ram_wdata = req.pixel_word;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = BLACK_WORD;
		end else if (acc && req.req_type == REQ_WRITE && wr_ok) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re      = (state_q == ST_RD);
	assign ram_raddr_a = {front_q, opp_q, LW'(LEDS - 1) - k_q};
	assign ram_raddr_b = {front_q, col_q, k_q};

	povcts_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_frame_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	povcts_div #(
		.COLUMNS(COLUMNS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.elapsed (dur),
		.period  (period_q),
		.done    (div_done),
		.column  (div_col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			min_turn_q   <= MIN_TURN_RESET;
			start_time_q <= '0;
			period_q     <= PERIOD_RESET;
			prev_col_q   <= '0;
			front_q      <= 1'b0;
			k_q          <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_turn_q <= cfg_wdata;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (req.req_type)
							REQ_HALL: begin
								if (dur > TIME_W'(min_turn_q)) begin
									period_q     <= dur;
									start_time_q <= req.timestamp_us;
								end
							end
							REQ_POLL: begin
								state_q <= ST_DIV;
							end
							REQ_PUBLISH: begin
								front_q <= !front_q;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (div_col == prev_col_q) begin
							state_q <= ST_IDLE;
						end else begin
							prev_col_q <= div_col;
							k_q        <= '0;
							state_q    <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_LD;
				end
				ST_LD: begin
					if (load) begin
						if (last_k) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			col_q <= div_col;
			opp_q <= opp_wrap[CW-1:0];
		end
		if (load) begin
			rsp_q.column_served  <= 8'(col_q);
			rsp_q.outer_arm_word <= ram_rdata_a;
			rsp_q.inner_arm_word <= ram_rdata_b;
			rsp_q.last_of_column <= last_k;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`POVCTS_ASSERT_NOW(a_write_back_bank, ram_we && state_q != ST_CLEAR,
		ram_waddr[AW-1] != front_q, "frame write hit the front bank")
	`POVCTS_ASSERT_NOW(a_no_write_during_read, ram_re, !ram_we,
		"frame ram written while serving a column")
	`POVCTS_ASSERT_NEXT(a_done_ends_div, div_done && state_q == ST_DIV,
		state_q == ST_IDLE || state_q == ST_RD, "column unit finished without leaving divide")

endmodule
